// ----- hw/rtl/centered_flip_pixel_blitter_unit_assert.svh -----
// Assertion macros used by the blitter checker file
`ifndef CENTERED_FLIP_PIXEL_BLITTER_UNIT_ASSERT_SVH
`define CENTERED_FLIP_PIXEL_BLITTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CFBP_ASSERT_HOLD(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CFBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cfbp_pkg.sv -----
// Shared types and constants of the centered flip pixel blitter
package cfbp_pkg;

    // Default sizing
    localparam int CFBP_MAX_DIM     = 4096;
    localparam int CFBP_QUEUE_DEPTH = 4;

    // Field widths
    localparam int DIM_W      = 13;
    localparam int STRIDE_W   = 15;
    localparam int FMT_W      = 2;
    localparam int CHAN_W     = 8;
    localparam int ADDR_W     = 26;
    localparam int WORD_W     = 24;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 56;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Pixel format codes
    localparam logic [FMT_W-1:0] FMT_NONE     = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB565   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_XRGB8888 = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_LINE_BYTES    = 3'd2;
    localparam logic [2:0] REG_PIXEL_FORMAT  = 3'd3;
    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd5;

    // Register reset values
    localparam logic [DIM_W-1:0]    RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]    RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [STRIDE_W-1:0] RST_LINE_BYTES    = 15'd2560;
    localparam logic [FMT_W-1:0]    RST_PIXEL_FORMAT  = FMT_NONE;
    localparam logic [DIM_W-1:0]    RST_SOURCE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]    RST_SOURCE_HEIGHT = 13'd480;

    // Configuration register file contents
    typedef struct packed {
        logic [DIM_W-1:0]    screen_width;
        logic [DIM_W-1:0]    screen_height;
        logic [STRIDE_W-1:0] line_bytes;
        logic [FMT_W-1:0]    pixel_format;
        logic [DIM_W-1:0]    source_width;
        logic [DIM_W-1:0]    source_height;
    } cfg_t;

    // One classified write waiting for address generation
    typedef struct packed {
        logic [DIM_W-1:0]  x;
        logic [DIM_W-1:0]  y;
        logic              wide;
        logic [WORD_W-1:0] word;
        logic              last;
    } queue_entry_t;

endpackage

// ----- hw/rtl/cfbp_front.sv -----
// Front end: pixel acceptance, position tracking, centering, flip and clipping
module cfbp_front #(
    parameter int MAX_DIM = cfbp_pkg::CFBP_MAX_DIM
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cfbp_pkg::cfg_t                 cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: red [7:0], green [15:8], blue [23:16]
    input  logic [cfbp_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           queue_full,
    output logic                           push,
    output cfbp_pkg::queue_entry_t         entry
);
    import cfbp_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int DLIM_W = CNT_W + 1;
    localparam int POS_W  = ((DLIM_W > DIM_W) ? DLIM_W : DIM_W) + 1;
    localparam logic [POS_W-1:0] MAX_DIM_P = POS_W'(MAX_DIM);
    localparam logic [POS_W-1:0] ONE_P     = POS_W'(1);

    logic [CNT_W-1:0] column_count_reg, column_count_next;
    logic [CNT_W-1:0] row_count_reg, row_count_next;

    logic [POS_W-1:0] w, h, ox, oy, c, r, x, y, c_inc, r_inc;
    logic [CHAN_W-1:0] red, green, blue;
    logic             fmt_ok, keep, last, accept;

    // Clamp a source dimension to 1..MAX_DIM
    function automatic logic [POS_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [POS_W-1:0] ext;
        ext = POS_W'(v);
        if (ext == '0) begin
            return ONE_P;
        end else if (ext > MAX_DIM_P) begin
            return MAX_DIM_P;
        end
        return ext;
    endfunction

    // Half the spare room, or zero when the source is at least as large
    function automatic logic [POS_W-1:0] centre_offset(input logic [DIM_W-1:0] screen,
                                                       input logic [POS_W-1:0] src);
        logic [POS_W-1:0] scr;
        scr = POS_W'(screen);
        if (scr > src) begin
            return (scr - src) >> 1;
        end
        return '0;
    endfunction

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // Locate the pixel on screen and decide whether it is written
    always_comb begin
        w  = clamp_dim(cfg.source_width);
        h  = clamp_dim(cfg.source_height);
        ox = centre_offset(cfg.screen_width, w);
        oy = centre_offset(cfg.screen_height, h);

        c = POS_W'(column_count_reg);
        if (c >= w) begin
            c = '0;
        end
        r = POS_W'(row_count_reg);
        if (r >= h) begin
            r = '0;
        end

        last = (c == w - ONE_P) && (r == h - ONE_P);
        x    = ox + c;
        y    = oy + (h - ONE_P - r);

        fmt_ok = (cfg.pixel_format == FMT_RGB565) || (cfg.pixel_format == FMT_XRGB8888);
        keep   = fmt_ok && (x < POS_W'(cfg.screen_width)) && (y < POS_W'(cfg.screen_height));

        // Advance the raster position, wrapping at row and frame end
        c_inc = c + ONE_P;
        r_inc = r + ONE_P;
        if (c_inc >= w) begin
            column_count_next = '0;
            row_count_next    = (r_inc >= h) ? '0 : r_inc[CNT_W-1:0];
        end else begin
            column_count_next = c_inc[CNT_W-1:0];
            row_count_next    = r[CNT_W-1:0];
        end
    end

    // Build the queue entry
    always_comb begin
        entry.x    = x[DIM_W-1:0];
        entry.y    = y[DIM_W-1:0];
        entry.wide = (cfg.pixel_format == FMT_XRGB8888);
        entry.last = last;
        if (cfg.pixel_format == FMT_XRGB8888) begin
            entry.word = {red, green, blue};
        end else begin
            entry.word = {8'h00, red[7:3], green[7:2], blue[7:3]};
        end
    end

    assign push = accept && keep;

    // Advance counters on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (accept) begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

// ----- hw/rtl/cfbp_queue.sv -----
// Short queue of classified writes between front and back ends
module cfbp_queue #(
    parameter int DEPTH = cfbp_pkg::CFBP_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  cfbp_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output cfbp_pkg::queue_entry_t head_entry
);
    import cfbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    queue_entry_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Store pushed entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/cfbp_back.sv -----
// Back end: byte address generation and the output register
module cfbp_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [cfbp_pkg::STRIDE_W-1:0]     line_bytes,
    input  logic                              head_valid,
    input  cfbp_pkg::queue_entry_t            head_entry,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: byte_address [25:0], pixel_word [49:26], zero pad [55:50]
    output logic [cfbp_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);
    import cfbp_pkg::*;

    localparam int PROD_W = DIM_W + STRIDE_W;
    localparam int COL_W  = DIM_W + 2;

    logic [PROD_W-1:0] row_base;
    logic [COL_W-1:0]  col_off;
    logic [ADDR_W-1:0] addr;

    logic              m_tvalid_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [WORD_W-1:0] word_reg;
    logic              last_reg;

    // Compute row*stride + column*bytes_per_pixel, wrapped to the address width
    always_comb begin
        row_base = PROD_W'(head_entry.y) * PROD_W'(line_bytes);
        col_off  = head_entry.wide ? {head_entry.x, 2'b00} : {1'b0, head_entry.x, 1'b0};
        addr     = row_base[ADDR_W-1:0] + ADDR_W'(col_off);
    end

    // Take the next entry when the output register is empty or draining
    assign pop = head_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (pop) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Load the payload with each popped entry, hold it otherwise
    always_ff @(posedge aclk) begin
        if (pop) begin
            addr_reg <= addr;
            word_reg <= head_entry.word;
            last_reg <= head_entry.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - ADDR_W - WORD_W){1'b0}}, word_reg, addr_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- hw/rtl/centered_flip_pixel_blitter_unit.sv -----
// Centered flip pixel blitter top level: config registers and front/queue/back
//
// Source pixels enter on the s_ stream, one beat per pixel in source memory
// order (bottom row first, each row left to right); alpha is not carried.
// Each pixel yields at most one framebuffer write beat on the m_ stream:
// byte address plus packed pixel, with m_tlast marking the last source pixel
// of the frame. Disabled or unknown formats and off-screen pixels produce no
// beat, but still advance the column and row counters.
// A kept pixel is held in the queue and then in the output register.
// Throughput: one pixel per clock while the queue has room, set by the front
// end position logic and the one-multiplier address stage in the back end.
// A four-entry queue separates the two; when m_tready is low the output beat
// holds and the queue fills, and s_tready drops only when the queue is full.
// Reset (aresetn low, synchronous) returns counters to zero, empties the
// queue and output register and loads the register defaults (640x480 screen
// and source, 2560-byte stride, display off). Write registers over APB only
// while the block is idle.
module centered_flip_pixel_blitter_unit #(
    parameter int MAX_DIM     = cfbp_pkg::CFBP_MAX_DIM,
    parameter int QUEUE_DEPTH = cfbp_pkg::CFBP_QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input pixel stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: red [7:0], green [15:8], blue [23:16]
    input  logic [cfbp_pkg::S_DATA_W-1:0]       s_tdata,
    // Framebuffer write stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: byte_address [25:0], pixel_word [49:26], zero pad [55:50]
    output logic [cfbp_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cfbp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cfbp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cfbp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import cfbp_pkg::*;

    cfg_t         cfg_reg;
    logic [2:0]   reg_idx;
    logic         cfg_write;
    logic         queue_full, push, pop, head_valid;
    queue_entry_t push_entry, head_entry;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.line_bytes    <= RST_LINE_BYTES;
            cfg_reg.pixel_format  <= RST_PIXEL_FORMAT;
            cfg_reg.source_width  <= RST_SOURCE_WIDTH;
            cfg_reg.source_height <= RST_SOURCE_HEIGHT;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= pwdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= pwdata[DIM_W-1:0];
                REG_LINE_BYTES:    cfg_reg.line_bytes    <= pwdata[STRIDE_W-1:0];
                REG_PIXEL_FORMAT:  cfg_reg.pixel_format  <= pwdata[FMT_W-1:0];
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= pwdata[DIM_W-1:0];
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (reg_idx)
            REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(cfg_reg.screen_height);
            REG_LINE_BYTES:    prdata = APB_DATA_W'(cfg_reg.line_bytes);
            REG_PIXEL_FORMAT:  prdata = APB_DATA_W'(cfg_reg.pixel_format);
            REG_SOURCE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.source_width);
            REG_SOURCE_HEIGHT: prdata = APB_DATA_W'(cfg_reg.source_height);
            default:           prdata = '0;
        endcase
    end

    cfbp_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .entry      (push_entry)
    );

    cfbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    cfbp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_bytes (cfg_reg.line_bytes),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- hw/rtl/cfbp_checker.sv -----
// Port-level checker for the blitter top level, with its bind
`include "centered_flip_pixel_blitter_unit_assert.svh"

module cfbp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [cfbp_pkg::M_DATA_W-1:0]       m_tdata,
    input logic                                m_tlast,
    input logic                                psel,
    input logic                                penable,
    input logic [cfbp_pkg::APB_DATA_W-1:0]     prdata,
    input logic                                pready
);
    import cfbp_pkg::*;

    // A stalled output beat keeps its payload
    `CFBP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output beat changed")

    // Pad bits above the pixel word stay zero
    `CFBP_ASSERT_HOLD(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_DATA_W-1:ADDR_W+WORD_W] == '0, "output pad bits not zero")

    // No register is wider than the stride, so upper read bits are zero
    `CFBP_ASSERT_HOLD(a_prdata_narrow, aclk, aresetn, psel, prdata[APB_DATA_W-1:STRIDE_W] == '0, "read data wider than any register")

    // The port never inserts wait states
    `CFBP_ASSERT_HOLD(a_no_wait, aclk, aresetn, psel && penable, pready, "config access stalled")

endmodule

bind centered_flip_pixel_blitter_unit cfbp_checker u_cfbp_checker (.*);

// ----- tb/testbench.sv -----
// Stream testbench for the centered flip pixel blitter: APB setup, pixel stimulus, write checks
`timescale 1ns / 100ps

module testbench;
    import cfbp_pkg::*;

    // Format code that the package leaves unnamed
    localparam logic [FMT_W-1:0] FMT_UNKNOWN = 2'd3;
    localparam int unsigned RGB565_BYTES = 16 / 8;
    localparam int unsigned XRGB_BYTES   = 32 / 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 30;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic              last;
    } fb_write_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the register file and the source position counters
    logic [DIM_W-1:0]    scr_w_reg  = RST_SCREEN_WIDTH;
    logic [DIM_W-1:0]    scr_h_reg  = RST_SCREEN_HEIGHT;
    logic [STRIDE_W-1:0] stride_reg = RST_LINE_BYTES;
    logic [FMT_W-1:0]    fmt_reg    = RST_PIXEL_FORMAT;
    logic [DIM_W-1:0]    src_w_reg  = RST_SOURCE_WIDTH;
    logic [DIM_W-1:0]    src_h_reg  = RST_SOURCE_HEIGHT;
    int unsigned         col_count  = 0;
    int unsigned         row_count  = 0;

    logic [S_DATA_W-1:0] pixels_pending[$];
    fb_write_t           fb_writes_due[$];
    int unsigned         pixels_queued   = 0;
    int unsigned         pixels_accepted = 0;
    int                  fail_count      = 0;
    int                  cycle_count     = 0;
    int                  src_idle_pct    = 20;
    int                  snk_idle_pct    = 53;

    centered_flip_pixel_blitter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Source size as the block sees it
    function automatic int unsigned dim_in_range(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > CFBP_MAX_DIM) return CFBP_MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned centre_offset(input int unsigned scr, input int unsigned src);
        return (scr > src) ? (scr - src) / 2 : 0;
    endfunction

    // Place one source pixel on screen, queue its write if kept, advance position
    task automatic blit_pixel(input logic [S_DATA_W-1:0] pix);
        int unsigned w, h, c, r, x, y, bpp;
        logic [CHAN_W-1:0] red, grn, blu;
        logic [31:0] addr;
        fb_write_t wr;
        w = dim_in_range(src_w_reg);
        h = dim_in_range(src_h_reg);
        c = col_count;
        r = row_count;
        red = pix[7:0];
        grn = pix[15:8];
        blu = pix[23:16];
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        x = centre_offset(scr_w_reg, w) + c;
        y = centre_offset(scr_h_reg, h) + (h - 1 - r);
        if ((fmt_reg == FMT_RGB565 || fmt_reg == FMT_XRGB8888) &&
            x < scr_w_reg && y < scr_h_reg) begin
            bpp = (fmt_reg == FMT_RGB565) ? RGB565_BYTES : XRGB_BYTES;
            addr = y * stride_reg + x * bpp;
            wr.addr = addr[ADDR_W-1:0];
            wr.word = (fmt_reg == FMT_RGB565) ? {8'h00, red[7:3], grn[7:2], blu[7:3]}
                                              : {red, grn, blu};
            wr.last = (c == w - 1) && (r == h - 1);
            fb_writes_due.push_back(wr);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_count = c;
        row_count = r;
    endtask

    // Drive source beats from the pending queue, predict on each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                blit_pixel(s_tdata);
                pixels_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pixels_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s_tdata  <= pixels_pending.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic note_failure(input string what, input fb_write_t want, input fb_write_t got,
                                input logic [M_DATA_W-ADDR_W-WORD_W-1:0] pad);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s: exp addr=%h word=%h last=%b got addr=%h word=%h last=%b pad=%h",
                     $realtime, what, want.addr, want.word, want.last,
                     got.addr, got.word, got.last, pad);
    endtask

    // Stall the write stream at random and check each write beat
    always @(posedge aclk) begin
        fb_write_t got, want;
        logic [M_DATA_W-ADDR_W-WORD_W-1:0] pad;
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.addr = m_tdata[ADDR_W-1:0];
            got.word = m_tdata[ADDR_W+WORD_W-1:ADDR_W];
            got.last = m_tlast;
            pad      = m_tdata[M_DATA_W-1:ADDR_W+WORD_W];
            if (fb_writes_due.size() == 0) begin
                note_failure("write with nothing due", '0, got, pad);
            end else begin
                want = fb_writes_due.pop_front();
                if (got.addr != want.addr || got.word != want.word ||
                    got.last != want.last || pad != '0)
                    note_failure("write mismatch", want, got, pad);
            end
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write every register and mirror it
    task automatic program_blit(input int unsigned sw, input int unsigned sh,
                                input int unsigned stride, input logic [FMT_W-1:0] fmt,
                                input int unsigned srcw, input int unsigned srch);
        reg_write(REG_SCREEN_WIDTH,  sw & 32'h1FFF);
        reg_write(REG_SCREEN_HEIGHT, sh & 32'h1FFF);
        reg_write(REG_LINE_BYTES,    stride & 32'h7FFF);
        reg_write(REG_PIXEL_FORMAT,  {30'd0, fmt});
        reg_write(REG_SOURCE_WIDTH,  srcw & 32'h1FFF);
        reg_write(REG_SOURCE_HEIGHT, srch & 32'h1FFF);
        scr_w_reg  = sw[DIM_W-1:0];
        scr_h_reg  = sh[DIM_W-1:0];
        stride_reg = stride[STRIDE_W-1:0];
        fmt_reg    = fmt;
        src_w_reg  = srcw[DIM_W-1:0];
        src_h_reg  = srch[DIM_W-1:0];
    endtask

    task automatic queue_pixel(input logic [7:0] red, input logic [7:0] grn,
                               input logic [7:0] blu);
        pixels_pending.push_back({blu, grn, red});
        pixels_queued++;
    endtask

    // Wait until every beat is in and every write is out, then let the pipe empty
    task automatic settle();
        while (pixels_accepted != pixels_queued || fb_writes_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned sw, sh, stride, srcw, srch, n, pick;
        logic [FMT_W-1:0] fmt;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: display off, counters still advance
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h12, 8'h34, 8'h56);
        settle();

        // Small centered frame in RGB565, channel extremes and dropped low bits
        program_blit(8, 6, 16, FMT_RGB565, 4, 3);
        queue_pixel(8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'hFF, 8'h00, 8'h00);
        queue_pixel(8'h00, 8'hFF, 8'h00);
        queue_pixel(8'h00, 8'h00, 8'hFF);
        queue_pixel(8'hAA, 8'h55, 8'hAA);
        queue_pixel(8'h07, 8'h03, 8'h07);
        queue_pixel(8'hF8, 8'hFC, 8'hF8);
        settle();

        // Same frame in XRGB8888
        program_blit(8, 6, 16, FMT_XRGB8888, 4, 3);
        queue_pixel(8'h55, 8'hAA, 8'h55);
        queue_pixel(8'h01, 8'h80, 8'hFE);
        queue_pixel(8'hFF, 8'h00, 8'hFF);
        settle();

        // Unknown format writes nothing
        program_blit(8, 6, 16, FMT_UNKNOWN, 4, 3);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h00, 8'h00, 8'h00);
        settle();

        // Source larger than screen: off-screen pixels dropped, last one too
        program_blit(2, 2, 4, FMT_RGB565, 4, 3);
        repeat (4) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        settle();

        // Zero source size counts as one pixel, minimal screen and stride
        program_blit(1, 1, 1, FMT_XRGB8888, 0, 0);
        queue_pixel(8'hC3, 8'h3C, 8'h99);
        queue_pixel(8'h00, 8'hFF, 8'h00);
        settle();

        // Oversized source clamps to the maximum; widest stride wraps the address
        program_blit(8191, 8191, 32767, FMT_XRGB8888, 8191, 8191);
        queue_pixel(8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h80, 8'h40, 8'h20);
        settle();
        program_blit(4096, 4096, 16384, FMT_RGB565, 4096, 4096);
        queue_pixel(8'h0F, 8'hF0, 8'h0F);
        settle();

        // Shrink the source under the counters: both positions restart
        program_blit(6, 6, 12, FMT_RGB565, 3, 3);
        repeat (4) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        settle();
        program_blit(6, 6, 12, FMT_RGB565, 1, 1);
        repeat (2) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        settle();

        // Random phases: small frames mostly, occasional extremes
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES / 3) begin
                src_idle_pct = 53;
                snk_idle_pct = 20;
            end
            if (ph == 2 * RANDOM_PHASES / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            pick = $urandom_range(0, 19);
            srcw = (pick < 17) ? $urandom_range(1, 8) : (pick == 17) ? 0 :
                   (pick == 18) ? $urandom_range(4097, 8191) : $urandom_range(1, 4096);
            pick = $urandom_range(0, 19);
            srch = (pick < 17) ? $urandom_range(1, 6) : (pick == 17) ? 0 :
                   (pick == 18) ? $urandom_range(4097, 8191) : $urandom_range(1, 4096);
            pick = $urandom_range(0, 9);
            sw = (pick < 7) ? $urandom_range(1, 16) :
                 (pick < 9) ? $urandom_range(1, 4096) : $urandom_range(1, 8191);
            pick = $urandom_range(0, 9);
            sh = (pick < 7) ? $urandom_range(1, 16) :
                 (pick < 9) ? $urandom_range(1, 4096) : $urandom_range(1, 8191);
            stride = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 64)
                                                : $urandom_range(1, 32767);
            pick = $urandom_range(0, 9);
            fmt = (pick == 0) ? FMT_NONE : (pick == 1) ? FMT_UNKNOWN :
                  (pick < 6) ? FMT_RGB565 : FMT_XRGB8888;
            program_blit(sw, sh, stride, fmt, srcw, srch);
            n = $urandom_range(12, 32);
            repeat (n) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom));
            settle();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
